// ===== design/tfpb_pkg.sv =====
// Package for the tilt fusion and balance controller.
// Holds widths, register indexes, the CORDIC arctangent table and direction codes.
// No dependencies.
package tfpb_pkg;

   localparam int CordicSteps = 16;
   localparam int FracBits = 8;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 17;

   localparam logic [CsrIdxWidth-1:0] REG_TARGET = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_GAIN_P = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_GAIN_I = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_GAIN_D = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_ILIMIT = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_DUTY_LO = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_DUTY_HI = 3'd6;
   localparam logic [CsrIdxWidth-1:0] REG_STOP = 3'd7;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_BACK = 2'd1;
   localparam logic [1:0] DIR_FWD = 2'd2;

   // Pi in Q30 radians; needs 33 bits signed headroom.
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

   // Configuration register set.
   typedef struct packed {
      logic [16:0] target_angle;
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [15:0] integral_limit;
      logic [6:0]  duty_low;
      logic [6:0]  duty_high;
      logic [15:0] stop_angle;
   } cfg_type;

   // Arctangent of 2^-i in Q30 radians.
   function automatic logic signed [33:0] atan_tab(input logic [4:0] i);
      logic signed [33:0] r;
      unique case (i)
         5'd0: r = 34'sh3243F6A8;  5'd1: r = 34'sh1DAC6705;
         5'd2: r = 34'sh0FADBAFC;  5'd3: r = 34'sh07F56EA6;
         5'd4: r = 34'sh03FEAB76;  5'd5: r = 34'sh01FFD55B;
         5'd6: r = 34'sh00FFFAAA;  5'd7: r = 34'sh007FFF55;
         5'd8: r = 34'sh003FFFEA;  5'd9: r = 34'sh001FFFFD;
         5'd10: r = 34'sh000FFFFF; 5'd11: r = 34'sh0007FFFF;
         5'd12: r = 34'sh0003FFFF; 5'd13: r = 34'sh0001FFFF;
         5'd14: r = 34'sh0000FFFF; 5'd15: r = 34'sh00007FFF;
         5'd16: r = 34'sh00003FFF; 5'd17: r = 34'sh00001FFF;
         5'd18: r = 34'sh00000FFF; 5'd19: r = 34'sh000007FF;
         5'd20: r = 34'sh000003FF; 5'd21: r = 34'sh000001FF;
         5'd22: r = 34'sh000000FF; 5'd23: r = 34'sh0000007F;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/tfpb_cordic.sv =====
// Iterative vectoring CORDIC that returns atan2(y, x) in 1/256 degree.
// Depends on tfpb_pkg. One micro-rotation per cycle, then a multiply for scaling.
module tfpb_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [16:0]  y_in,
   input  logic signed [16:0]  x_in,
   output logic                done,
   output logic signed [16:0]  angle
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ITER = 3'd1;
   localparam logic [2:0] ST_MUL = 3'd2;
   localparam logic [2:0] ST_RND = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // Divisor 11 << 22 for the radian to degree conversion.
   localparam logic [47:0] Den = 48'd11 << (30 - tfpb_pkg::FracBits);

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic signed [33:0] x_ff, x_in_r, y_ff, y_in_r, z_ff, z_in;
   logic neg_ff, neg_in;
   logic [47:0] prod_ff, prod_in;
   logic signed [16:0] angle_ff, angle_in;

   logic signed [33:0] dx, dy, zabs;
   logic [47:0] q;
   logic [47:0] num;
   logic [23:0] qv;
   logic [47:0] qm;

   assign dx = x_ff >>> step_ff;
   assign dy = y_ff >>> step_ff;
   assign zabs = z_ff[33] ? -z_ff : z_ff;
   assign num = prod_ff + (Den >> 1);
   // Quotient by constant 11<<22: shift away 22 bits, then multiply by the
   // reciprocal ceil(2^26/11); the result is exact for values below 2^25.
   assign qv = 24'(num >> (30 - tfpb_pkg::FracBits));
   assign qm = 48'(qv) * 48'd6100806;
   assign q = qm >> 26;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      x_in_r = x_ff;
      y_in_r = y_ff;
      z_in = z_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      angle_in = angle_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               step_in = '0;
               if (y_in == 17'sd0) begin
                  z_in = (x_in < 0) ? tfpb_pkg::PI_Q30 : 34'sd0;
                  x_in_r = '0;
                  y_in_r = '0;
                  state_in = ST_MUL;
               end else begin
                  if (x_in < 0) begin
                     z_in = (y_in > 0) ? tfpb_pkg::PI_Q30 : -tfpb_pkg::PI_Q30;
                     x_in_r = -(34'(x_in) <<< 14);
                     y_in_r = -(34'(y_in) <<< 14);
                  end else begin
                     z_in = '0;
                     x_in_r = 34'(x_in) <<< 14;
                     y_in_r = 34'(y_in) <<< 14;
                  end
                  state_in = ST_ITER;
               end
            end
         end
         ST_ITER: begin
            if (!y_ff[33]) begin
               x_in_r = x_ff + dy;
               y_in_r = y_ff - dx;
               z_in = z_ff + tfpb_pkg::atan_tab(step_ff);
            end else begin
               x_in_r = x_ff - dy;
               y_in_r = y_ff + dx;
               z_in = z_ff - tfpb_pkg::atan_tab(step_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(tfpb_pkg::CordicSteps - 1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            neg_in = z_ff[33];
            prod_in = 48'(zabs) * 48'd630;
            state_in = ST_RND;
         end
         ST_RND: begin
            angle_in = (q > 48'd65535) ? (neg_ff ? -17'sd65535 : 17'sd65535)
                     : (neg_ff ? -$signed({1'b0, q[15:0]}) : $signed({1'b0, q[15:0]}));
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      step_ff <= step_in;
      x_ff <= x_in_r;
      y_ff <= y_in_r;
      z_ff <= z_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      angle_ff <= angle_in;
   end

   assign done = (state_ff == ST_DONE);
   assign angle = angle_ff;

endmodule

// ===== design/tfpb_ctrl.sv =====
// Fusion and PID arithmetic, sequenced over one shared multiplier.
// Depends on tfpb_pkg. Holds the estimates and PID state.
module tfpb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tfpb_pkg::cfg_type   cfg,
   input  logic signed [16:0]  roll_acc,
   input  logic signed [16:0]  pitch_acc,
   input  logic signed [15:0]  gyro_x,
   input  logic signed [15:0]  gyro_y,
   input  logic [19:0]         elapsed_us,
   output logic                done,
   output logic signed [16:0]  roll_out,
   output logic signed [16:0]  pitch_out,
   output logic signed [31:0]  corr_out,
   output logic [14:0]         duty_out,
   output logic [1:0]          dir_out
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RATE = 4'd1;
   localparam logic [3:0] S_DMUL = 4'd2;
   localparam logic [3:0] S_DDIV = 4'd3;
   localparam logic [3:0] S_FUSE = 4'd4;
   localparam logic [3:0] S_PMUL = 4'd5;
   localparam logic [3:0] S_IMUL = 4'd6;
   localparam logic [3:0] S_DMUL2 = 4'd7;
   localparam logic [3:0] S_OUT = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic axis_ff, axis_in;
   logic seen_ff, seen_in;
   logic signed [16:0] roll_ff, roll_in, pitch_ff, pitch_in;
   logic signed [17:0] prev_ff, prev_in, sum_ff, sum_in, err_ff, err_in;
   logic signed [18:0] diff_ff, diff_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] tmp_ff, tmp_in;
   logic signed [31:0] corr_ff, corr_in;
   logic [14:0] duty_ff, duty_in;
   logic [1:0] dir_ff, dir_in;

   // Shared multiplier operands.
   logic signed [33:0] ma, mb;
   logic signed [67:0] mp;
   assign mp = ma * mb;

   logic signed [15:0] gsel;
   logic signed [16:0] gabs;
   logic signed [16:0] est_sel, acc_sel;
   logic signed [47:0] mag, fz, fq, dq;
   logic [30:0] dw;
   logic [20:0] fw;
   logic signed [17:0] pmag, err_w, sum_w;
   logic signed [18:0] lim;
   logic signed [47:0] cs;
   logic [31:0] acorr;
   logic [15:0] lo, hi, dsel;

   assign gsel = axis_ff ? gyro_y : gyro_x;
   assign gabs = gsel[15] ? -17'(gsel) : 17'(gsel);
   assign est_sel = axis_ff ? pitch_ff : roll_ff;
   assign acc_sel = axis_ff ? pitch_acc : roll_acc;

   // Rounded quotients by reciprocal multiplication on the shared multiplier;
   // magnitudes are rounded with halves away from zero.
   // Divide by 10^6: drop 6 bits, then multiply by ceil(2^45/15625).
   assign mag = tmp_ff[47] ? -tmp_ff : tmp_ff;
   assign dw = 31'((mag + 48'sd500000) >>> 6);
   assign dq = 48'(mp >>> 45);
   // Divide by 10: drop 1 bit, then multiply by ceil(2^22/5).
   assign fz = 48'sd9 * (48'(est_sel) + acc_ff) + 48'(acc_sel);
   assign fw = 21'(((fz[47] ? -fz : fz) + 48'sd5) >>> 1);
   assign fq = 48'(mp >>> 22);

   assign pmag = pitch_acc[16] ? -18'(pitch_acc) : 18'(pitch_acc);
   assign err_w = 18'($signed({1'b0, cfg.target_angle})) - pmag;
   assign lim = 19'($signed({1'b0, cfg.integral_limit}));
   assign cs = acc_ff >>> 8;
   assign acorr = corr_ff[31] ? 32'(-33'(corr_ff)) : 32'(corr_ff);
   assign lo = 16'(cfg.duty_low) << tfpb_pkg::FracBits;
   assign hi = 16'(cfg.duty_high) << tfpb_pkg::FracBits;

   always_comb begin
      logic signed [18:0] s;
      s = 19'(sum_ff) + 19'(err_w);
      sum_w = (s < -lim) ? 18'(-lim) : ((s > lim) ? 18'(lim) : 18'(s));
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      seen_in = seen_ff;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      prev_in = prev_ff;
      sum_in = sum_ff;
      err_in = err_ff;
      diff_in = diff_ff;
      acc_in = acc_ff;
      tmp_in = tmp_ff;
      corr_in = corr_ff;
      duty_in = duty_ff;
      dir_in = dir_ff;
      ma = '0;
      mb = '0;
      dsel = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               axis_in = 1'b0;
               if (!seen_ff) begin
                  roll_in = roll_acc;
                  pitch_in = pitch_acc;
                  seen_in = 1'b1;
                  state_in = S_PMUL;
               end else begin
                  state_in = S_RATE;
               end
               err_in = err_w;
               diff_in = 19'(err_w) - 19'(prev_ff);
               sum_in = sum_w;
               acc_in = '0;
            end
         end
         // Gyro rate truncated toward zero: magnitude times ceil(2^24/131).
         S_RATE: begin
            ma = 34'(gabs);
            mb = 34'sd128071;
            tmp_in = gsel[15] ? -48'(mp >>> 24) : 48'(mp >>> 24);
            state_in = S_DMUL;
         end
         // Rate times elapsed time and 2^F.
         S_DMUL: begin
            ma = 34'(tmp_ff);
            mb = 34'($signed({1'b0, elapsed_us}));
            tmp_in = 48'(mp) <<< tfpb_pkg::FracBits;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            ma = 34'(dw);
            mb = 34'sd2251799814;
            acc_in = tmp_ff[47] ? -dq : dq;
            state_in = S_FUSE;
         end
         S_FUSE: begin
            ma = 34'(fw);
            mb = 34'sd838861;
            if (!axis_ff) begin
               roll_in = (fz[47] ? -fq : fq) < -48'sd65536 ? -17'sd65536 :
                         ((fz[47] ? -fq : fq) > 48'sd65535 ? 17'sd65535 :
                          17'(fz[47] ? -fq : fq));
               axis_in = 1'b1;
               state_in = S_RATE;
            end else begin
               pitch_in = (fz[47] ? -fq : fq) < -48'sd65536 ? -17'sd65536 :
                          ((fz[47] ? -fq : fq) > 48'sd65535 ? 17'sd65535 :
                           17'(fz[47] ? -fq : fq));
               state_in = S_PMUL;
            end
            acc_in = '0;
         end
         S_PMUL: begin
            ma = 34'($signed({1'b0, cfg.gain_p}));
            mb = 34'(err_ff);
            acc_in = 48'(mp);
            state_in = S_IMUL;
         end
         S_IMUL: begin
            ma = 34'($signed({1'b0, cfg.gain_i}));
            mb = 34'(sum_ff);
            acc_in = acc_ff + 48'(mp);
            state_in = S_DMUL2;
         end
         S_DMUL2: begin
            ma = 34'($signed({1'b0, cfg.gain_d}));
            mb = 34'(diff_ff);
            acc_in = acc_ff - 48'(mp);
            prev_in = err_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            corr_in = (cs > 48'sd2147483647) ? 32'sh7FFFFFFF :
                      ((cs < -48'sd2147483648) ? 32'sh80000000 : 32'(cs));
            if (pitch_acc > 0 && 18'(pitch_acc) < 18'($signed({1'b0, cfg.stop_angle})))
               dir_in = tfpb_pkg::DIR_BACK;
            else if (pitch_acc < 0 &&
                     18'(pitch_acc) > -18'($signed({1'b0, cfg.stop_angle})))
               dir_in = tfpb_pkg::DIR_FWD;
            else
               dir_in = tfpb_pkg::DIR_STOP;
            state_in = S_DONE;
         end
         S_DONE: begin
            priority if (acorr < 32'(lo)) dsel = lo;
            else if (acorr > 32'(hi)) dsel = hi;
            else dsel = acorr[15:0];
            duty_in = (dir_ff == tfpb_pkg::DIR_STOP) ? 15'd0 :
                      (dsel > 16'd32767 ? 15'd32767 : dsel[14:0]);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seen_ff <= 1'b0;
         roll_ff <= '0;
         pitch_ff <= '0;
         prev_ff <= '0;
         sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
         roll_ff <= roll_in;
         pitch_ff <= pitch_in;
         prev_ff <= prev_in;
         sum_ff <= sum_in;
      end
      axis_ff <= axis_in;
      err_ff <= err_in;
      diff_ff <= diff_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      corr_ff <= corr_in;
      duty_ff <= duty_in;
      dir_ff <= dir_in;
   end

   assign done = (state_ff == S_DONE);
   assign roll_out = roll_ff;
   assign pitch_out = pitch_ff;
   assign corr_out = corr_ff;
   assign duty_out = duty_in;
   assign dir_out = dir_ff;

endmodule

// ===== design/tilt_fusion_pid_balancer_unit.sv =====
// Top level of the tilt fusion and balance controller.
// Depends on tfpb_pkg, tfpb_cordic and tfpb_ctrl.
//
// Usage: a request transaction carries raw accelerometer axes, two gyro rates
// and the elapsed microseconds. One response transaction follows per request
// with filtered roll and pitch, accelerometer pitch, PID correction, duty and
// direction. The user must see that registers are written over the csr_ port
// only while the block is idle; the block itself does not enforce this.
//
// The roll pass on the shared rotation unit (setup, 16 micro-rotations, scaling
// and rounding) comes first, then the pitch pass after its handoff register,
// then fusion and PID work on one shared multiplier, and then the response is
// offered. A zero ordinate skips the micro-rotations and the first transaction
// after reset skips the fusion steps, so those finish sooner. One transaction
// is in flight at a time.
//
// Reset clears estimates, PID state and registers to their defaults; the first
// transaction afterwards loads the estimates from the accelerometer angles.
// When the receiver stalls, the response is held in the output register and
// req_ready stays low until it is taken.
module tilt_fusion_pid_balancer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [15:0]  req_gyro_x,
   input  logic signed [15:0]  req_gyro_y,
   input  logic [19:0]         req_elapsed_us,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [16:0]  rsp_roll_filtered,
   output logic signed [16:0]  rsp_pitch_filtered,
   output logic signed [16:0]  rsp_pitch_accel,
   output logic signed [31:0]  rsp_correction,
   output logic [14:0]         rsp_duty,
   output logic [1:0]          rsp_direction,
   input  logic                csr_write,
   input  logic [tfpb_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [tfpb_pkg::CsrDataWidth-1:0] csr_data
);

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_ROLL = 3'd1;
   localparam logic [2:0] T_PITCH = 3'd2;
   localparam logic [2:0] T_CTRL = 3'd3;
   localparam logic [2:0] T_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   tfpb_pkg::cfg_type cfg_ff;
   logic signed [15:0] ax_ff, az_ff, gx_ff, gy_ff;
   logic [19:0] el_ff;
   logic signed [16:0] roll_acc_ff, pitch_acc_ff;

   logic c_start, c_done;
   logic signed [16:0] c_y, c_x, c_angle;
   logic p_go_ff;
   logic k_start, k_done;
   logic signed [16:0] k_roll, k_pitch;
   logic signed [31:0] k_corr;
   logic [14:0] k_duty;
   logic [1:0] k_dir;

   logic signed [16:0] o_roll_ff, o_pitch_ff, o_pacc_ff;
   logic signed [31:0] o_corr_ff;
   logic [14:0] o_duty_ff;
   logic [1:0] o_dir_ff;

   logic accept;
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == T_IDLE);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= 17'd46080;
         cfg_ff.gain_p <= 16'd2048;
         cfg_ff.gain_i <= 16'd0;
         cfg_ff.gain_d <= 16'd256;
         cfg_ff.integral_limit <= 16'd10240;
         cfg_ff.duty_low <= 7'd60;
         cfg_ff.duty_high <= 7'd70;
         cfg_ff.stop_angle <= 16'd45568;
      end else if (csr_write) begin
         unique case (csr_index)
            tfpb_pkg::REG_TARGET: cfg_ff.target_angle <= csr_data;
            tfpb_pkg::REG_GAIN_P: cfg_ff.gain_p <= csr_data[15:0];
            tfpb_pkg::REG_GAIN_I: cfg_ff.gain_i <= csr_data[15:0];
            tfpb_pkg::REG_GAIN_D: cfg_ff.gain_d <= csr_data[15:0];
            tfpb_pkg::REG_ILIMIT: cfg_ff.integral_limit <= csr_data[15:0];
            tfpb_pkg::REG_DUTY_LO: cfg_ff.duty_low <= csr_data[6:0];
            tfpb_pkg::REG_DUTY_HI: cfg_ff.duty_high <= csr_data[6:0];
            tfpb_pkg::REG_STOP: cfg_ff.stop_angle <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer over the two CORDIC passes and the control pass.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: if (accept) state_in = T_ROLL;
         T_ROLL: if (c_done) state_in = T_PITCH;
         T_PITCH: if (c_done) state_in = T_CTRL;
         T_CTRL: if (k_done) state_in = T_RESP;
         T_RESP: if (rsp_ready) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   // The pitch pass starts once the rotation unit is back in its idle state.
   always_ff @(posedge clock) begin
      if (reset) p_go_ff <= 1'b0;
      else p_go_ff <= (state_ff == T_ROLL) && c_done;
   end

   assign c_start = (state_ff == T_IDLE && accept) || (state_ff == T_PITCH && p_go_ff);
   assign c_y = (state_ff == T_IDLE) ? 17'(req_accel_y) : -17'(ax_ff);
   assign c_x = (state_ff == T_IDLE) ? 17'(req_accel_z) : 17'(az_ff);
   assign k_start = (state_ff == T_PITCH) && c_done;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= T_IDLE;
      else state_ff <= state_in;
      if (accept) begin
         ax_ff <= req_accel_x;
         az_ff <= req_accel_z;
         gx_ff <= req_gyro_x;
         gy_ff <= req_gyro_y;
         el_ff <= req_elapsed_us;
      end
      if (state_ff == T_ROLL && c_done) roll_acc_ff <= c_angle;
      if (state_ff == T_PITCH && c_done) pitch_acc_ff <= c_angle;
      if (k_done) begin
         o_roll_ff <= k_roll;
         o_pitch_ff <= k_pitch;
         o_pacc_ff <= pitch_acc_ff;
         o_corr_ff <= k_corr;
         o_duty_ff <= k_duty;
         o_dir_ff <= k_dir;
      end
   end

   tfpb_cordic u_cordic (
      .clock(clock), .reset(reset), .start(c_start), .y_in(c_y), .x_in(c_x),
      .done(c_done), .angle(c_angle)
   );

   // The control pass starts the cycle after the pitch angle is stored.
   logic k_go_ff;
   always_ff @(posedge clock) begin
      if (reset) k_go_ff <= 1'b0;
      else k_go_ff <= k_start;
   end

   tfpb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(k_go_ff), .cfg(cfg_ff),
      .roll_acc(roll_acc_ff), .pitch_acc(pitch_acc_ff),
      .gyro_x(gx_ff), .gyro_y(gy_ff), .elapsed_us(el_ff),
      .done(k_done), .roll_out(k_roll), .pitch_out(k_pitch),
      .corr_out(k_corr), .duty_out(k_duty), .dir_out(k_dir)
   );

   assign rsp_valid = (state_ff == T_RESP);
   assign rsp_roll_filtered = o_roll_ff;
   assign rsp_pitch_filtered = o_pitch_ff;
   assign rsp_pitch_accel = o_pacc_ff;
   assign rsp_correction = o_corr_ff;
   assign rsp_duty = o_duty_ff;
   assign rsp_direction = o_dir_ff;

   // A stopped drive reports zero duty.
   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction == tfpb_pkg::DIR_STOP |-> rsp_duty == 15'd0)
      else $error("duty nonzero while stopped");
   // No new request while a response waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted during response");
   // Direction never takes the unused code.
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction != 2'd3)
      else $error("bad direction code");

endmodule

// ===== tb/tb.sv =====
// Testbench for tilt_fusion_pid_balancer_unit: random and directed IMU samples,
// predicted with a bit-accurate model of CORDIC fusion and PID, checked per field.
// Depends on tfpb_pkg and the design top level.
`timescale 1ns / 1ps

module tb;

   localparam int WatchdogLimit = 20000;
   localparam longint PiQ30 = 64'sd3373259426;

   typedef struct packed {
      logic signed [15:0] ax, ay, az, gx, gy;
      logic [19:0]        el;
   } sample_type;

   typedef struct packed {
      logic signed [16:0] roll, pitch, pacc;
      logic signed [31:0] corr;
      logic [14:0]        duty;
      logic [1:0]         dir;
   } balance_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, req_ready, rsp_valid;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0] req_gyro_x = 0, req_gyro_y = 0;
   logic [19:0] req_elapsed_us = 0;
   logic signed [16:0] rsp_roll_filtered, rsp_pitch_filtered, rsp_pitch_accel;
   logic signed [31:0] rsp_correction;
   logic [14:0] rsp_duty;
   logic [1:0] rsp_direction;
   logic csr_write = 0;
   logic [tfpb_pkg::CsrIdxWidth-1:0] csr_index = 0;
   logic [tfpb_pkg::CsrDataWidth-1:0] csr_data = 0;

   tilt_fusion_pid_balancer_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state and register copy.
   longint m_target, m_kp, m_ki, m_kd, m_ilim, m_dlo, m_dhi, m_stop;
   longint m_roll, m_pitch, m_prev_err, m_err_sum;
   bit m_seen;

   sample_type  pending_samples[$];
   balance_type expected_outputs[$];
   int error_count = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   bit hold_off = 0;
   int idle_cycles = 0;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint m, q;
      m = num < 0 ? -num : num;
      q = (m + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint atan_q30(int i);
      longint tab[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
         64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
         64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
         64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      return tab[i];
   endfunction

   // Arctangent in Q30 radians, then degrees in 1/256 units.
   function automatic longint tilt_angle(longint y, longint x);
      longint base, z, dx, dy, m, den, q;
      base = 0; z = 0;
      if (y == 0) begin
         z = x < 0 ? PiQ30 : 0;
      end else begin
         if (x < 0) begin
            base = y > 0 ? PiQ30 : -PiQ30;
            x = -x; y = -y;
         end
         x = x * 16384; y = y * 16384;
         for (int i = 0; i < tfpb_pkg::CordicSteps && i < 24; i++) begin
            dx = shr_floor(x, i); dy = shr_floor(y, i);
            if (y >= 0) begin
               x += dy; y -= dx; z += atan_q30(i);
            end else begin
               x -= dy; y += dx; z -= atan_q30(i);
            end
         end
         z = base + z;
      end
      m = (z < 0 ? -z : z) * 630;
      den = 64'sd11 << (30 - tfpb_pkg::FracBits);
      q = (m + den / 2) / den;
      if (q > 65535) q = 65535;
      return z < 0 ? -q : q;
   endfunction

   function automatic longint blend(longint est, longint acc, longint gyro, longint el);
      longint rate, delta;
      rate = gyro / 131;
      delta = div_round(rate * el * (64'sd1 << tfpb_pkg::FracBits), 1000000);
      return clamp(div_round(9 * (est + delta) + acc, 10), -65536, 65535);
   endfunction

   function automatic balance_type predict_balance(sample_type s);
      balance_type r;
      longint racc, pacc, mag, err, diff, corr, acorr, lo, hi, duty;
      logic [1:0] dir;
      racc = tilt_angle(s.ay, s.az);
      pacc = tilt_angle(-longint'(s.ax), s.az);
      if (!m_seen) begin
         m_roll = racc; m_pitch = pacc; m_seen = 1;
      end else begin
         m_roll = blend(m_roll, racc, s.gx, s.el);
         m_pitch = blend(m_pitch, pacc, s.gy, s.el);
      end
      mag = pacc < 0 ? -pacc : pacc;
      err = m_target - mag;
      diff = err - m_prev_err;
      m_err_sum = clamp(m_err_sum + err, -m_ilim, m_ilim);
      corr = shr_floor(m_kp * err + m_ki * m_err_sum - m_kd * diff, 8);
      corr = clamp(corr, -64'sd2147483648, 64'sd2147483647);
      m_prev_err = err;
      acorr = corr < 0 ? -corr : corr;
      lo = m_dlo << tfpb_pkg::FracBits; hi = m_dhi << tfpb_pkg::FracBits;
      duty = acorr < lo ? lo : (acorr > hi ? hi : acorr);
      if (duty > 32767) duty = 32767;
      if (pacc > 0 && pacc < m_stop) dir = tfpb_pkg::DIR_BACK;
      else if (pacc < 0 && pacc > -m_stop) dir = tfpb_pkg::DIR_FWD;
      else dir = tfpb_pkg::DIR_STOP;
      if (dir == tfpb_pkg::DIR_STOP) duty = 0;
      r.roll = m_roll[16:0]; r.pitch = m_pitch[16:0]; r.pacc = pacc[16:0];
      r.corr = corr[31:0]; r.duty = duty[14:0]; r.dir = dir;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: offers queued samples, idling at random between transactions.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_outputs.push_back(predict_balance(
               {req_accel_x, req_accel_y, req_accel_z, req_gyro_x, req_gyro_y,
                req_elapsed_us}));
            void'(pending_samples.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               {req_accel_x, req_accel_y, req_accel_z, req_gyro_x, req_gyro_y,
                req_elapsed_us} <= pending_samples[0];
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Receiver: stalls at random, or holds off entirely during the pressure phase.
   always @(posedge clock) begin
      if (!reset) rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: compares each response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            balance_type w;
            w = expected_outputs.pop_front();
            if (rsp_roll_filtered !== w.roll)
               report_mismatch("roll_filtered", rsp_roll_filtered, w.roll);
            if (rsp_pitch_filtered !== w.pitch)
               report_mismatch("pitch_filtered", rsp_pitch_filtered, w.pitch);
            if (rsp_pitch_accel !== w.pacc)
               report_mismatch("pitch_accel", rsp_pitch_accel, w.pacc);
            if (rsp_correction !== w.corr)
               report_mismatch("correction", rsp_correction, w.corr);
            if (rsp_duty !== w.duty) report_mismatch("duty", rsp_duty, w.duty);
            if (rsp_direction !== w.dir)
               report_mismatch("direction", rsp_direction, w.dir);
         end
      end
   end

   // Watchdog: counts cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || hold_off)
         idle_cycles <= 0;
      else if (pending_samples.size() != 0 || expected_outputs.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("[tilt_fusion_pid_balancer_unit] ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [tfpb_pkg::CsrIdxWidth-1:0] idx, longint val);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= val[tfpb_pkg::CsrDataWidth-1:0];
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         tfpb_pkg::REG_TARGET:  m_target = val & 64'h1FFFF;
         tfpb_pkg::REG_GAIN_P:  m_kp = val & 64'hFFFF;
         tfpb_pkg::REG_GAIN_I:  m_ki = val & 64'hFFFF;
         tfpb_pkg::REG_GAIN_D:  m_kd = val & 64'hFFFF;
         tfpb_pkg::REG_ILIMIT:  m_ilim = val & 64'hFFFF;
         tfpb_pkg::REG_DUTY_LO: m_dlo = val & 64'h7F;
         tfpb_pkg::REG_DUTY_HI: m_dhi = val & 64'h7F;
         tfpb_pkg::REG_STOP:    m_stop = val & 64'hFFFF;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      int k;
      s = sample_type'(100'({$urandom, $urandom, $urandom, $urandom}));
      k = $urandom_range(9);
      // Mostly realistic tilts with dominant z; else noise, some with x or y zero.
      if (k < 6) begin
         s.az = 16'sd12384 + $signed(16'($urandom_range(8000)));
         if ($urandom_range(1)) s.az = -s.az;
         s.ax = 16'(int'($urandom_range(24000)) - 12000);
         s.ay = 16'(int'($urandom_range(24000)) - 12000);
         s.el = 20'($urandom_range(20000));
      end else if (k == 6) begin
         s.ax = 0;
      end else if (k == 7) begin
         s.ay = 0;
      end
      return s;
   endfunction

   task automatic run_phase(int count, int idle, int stall);
      send_idle_pct = idle; recv_stall_pct = stall;
      repeat (count) pending_samples.push_back(random_sample());
      wait_drained();
   endtask

   initial begin
      sample_type d;
      m_target = 46080; m_kp = 2048; m_ki = 0; m_kd = 256; m_ilim = 10240;
      m_dlo = 60; m_dhi = 70; m_stop = 45568;
      m_roll = 0; m_pitch = 0; m_prev_err = 0; m_err_sum = 0; m_seen = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, zero ordinates, negative abscissa, atan2(0,0).
      d = '0; pending_samples.push_back(d);
      d = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 20'hFFFFF};
      pending_samples.push_back(d);
      d = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 20'hFFFFF};
      pending_samples.push_back(d);
      d = '{16'sd0, 16'sd0, -16'sd1000, 16'sd130, -16'sd131, 20'd1000};
      pending_samples.push_back(d);
      d = '{16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 20'd0};
      pending_samples.push_back(d);
      d = '{16'sd500, -16'sd500, -16'sd2000, 16'sd262, 16'sd999, 20'd5000};
      pending_samples.push_back(d);
      d = '{-16'sd500, 16'sd500, -16'sd2000, -16'sd262, 16'sd1, 20'd5000};
      pending_samples.push_back(d);
      d = '{16'sd8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1};
      pending_samples.push_back(d);
      d = '{-16'sd8000, 16'sd8000, 16'sd0, 16'sd0, 16'sd0, 20'd1};
      pending_samples.push_back(d);
      wait_drained();

      run_phase(150, 0, 0);

      // Extreme settings: large gains, inverted duty range, zero limits.
      write_reg(tfpb_pkg::REG_TARGET, 92160); write_reg(tfpb_pkg::REG_GAIN_P, 65535);
      write_reg(tfpb_pkg::REG_GAIN_I, 65535); write_reg(tfpb_pkg::REG_GAIN_D, 0);
      write_reg(tfpb_pkg::REG_ILIMIT, 65535); write_reg(tfpb_pkg::REG_DUTY_LO, 100);
      write_reg(tfpb_pkg::REG_DUTY_HI, 0); write_reg(tfpb_pkg::REG_STOP, 46080);
      run_phase(200, 73, 0);

      write_reg(tfpb_pkg::REG_TARGET, 0); write_reg(tfpb_pkg::REG_GAIN_P, 0);
      write_reg(tfpb_pkg::REG_GAIN_I, 300); write_reg(tfpb_pkg::REG_GAIN_D, 65535);
      write_reg(tfpb_pkg::REG_ILIMIT, 0); write_reg(tfpb_pkg::REG_DUTY_LO, 0);
      write_reg(tfpb_pkg::REG_DUTY_HI, 100); write_reg(tfpb_pkg::REG_STOP, 0);
      run_phase(200, 0, 73);

      // Pressure: receiver holds off while the sender keeps offering.
      write_reg(tfpb_pkg::REG_TARGET, $urandom_range(92160));
      write_reg(tfpb_pkg::REG_GAIN_P, $urandom_range(65535));
      write_reg(tfpb_pkg::REG_GAIN_I, $urandom_range(65535));
      write_reg(tfpb_pkg::REG_GAIN_D, $urandom_range(65535));
      write_reg(tfpb_pkg::REG_ILIMIT, $urandom_range(65535));
      write_reg(tfpb_pkg::REG_DUTY_LO, $urandom_range(100));
      write_reg(tfpb_pkg::REG_DUTY_HI, $urandom_range(100));
      write_reg(tfpb_pkg::REG_STOP, $urandom_range(46080));
      send_idle_pct = 0; recv_stall_pct = 0;
      repeat (20) pending_samples.push_back(random_sample());
      hold_off = 1;
      repeat (600) @(posedge clock);
      hold_off = 0;
      wait_drained();

      run_phase(200, 20, 20);
      write_reg(tfpb_pkg::REG_TARGET, 46080); write_reg(tfpb_pkg::REG_GAIN_P, 2048);
      write_reg(tfpb_pkg::REG_GAIN_I, 16); write_reg(tfpb_pkg::REG_GAIN_D, 256);
      write_reg(tfpb_pkg::REG_ILIMIT, 10240); write_reg(tfpb_pkg::REG_DUTY_LO, 60);
      write_reg(tfpb_pkg::REG_DUTY_HI, 70); write_reg(tfpb_pkg::REG_STOP, 45568);
      run_phase(300, 0, 0);

      if (error_count == 0)
         $display("[tilt_fusion_pid_balancer_unit] OK");
      else
         $display("[tilt_fusion_pid_balancer_unit] ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
design/tfpb_pkg.sv
design/tfpb_cordic.sv
design/tfpb_ctrl.sv
design/tilt_fusion_pid_balancer_unit.sv
tb/tb.sv
